// ===== rtl/arc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_pkg
// Shared types, codes and constants of the ARP responder cache.
// ----------------------------------------------------------------------------
package arc_pkg;

  localparam int CACHE_SLOTS_DEF = 16;

  localparam int IN_DATA_W  = 232;
  localparam int OUT_DATA_W = 216;

  localparam logic [1:0] CMD_PACKET  = 2'd0;
  localparam logic [1:0] CMD_RESOLVE = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;
  localparam logic [1:0] CMD_INSTALL = 2'd3;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_REPLY   = 3'd1;
  localparam logic [2:0] ACT_REQUEST = 3'd2;
  localparam logic [2:0] ACT_RREPLY  = 3'd3;
  localparam logic [2:0] ACT_RESOLVE = 3'd4;
  localparam logic [2:0] ACT_QUENCH  = 3'd6;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_HW  = 3'd1;
  localparam logic [2:0] ST_BAD_PRO = 3'd2;
  localparam logic [2:0] ST_BAD_LEN = 3'd3;
  localparam logic [2:0] ST_BCAST   = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;
  localparam logic [2:0] ST_IGNORED = 3'd6;

  localparam logic [15:0] OP_REQUEST  = 16'd1;
  localparam logic [15:0] OP_RREQUEST = 16'd3;
  localparam logic [2:0]  OPO_REQUEST = 3'd1;
  localparam logic [2:0]  OPO_REPLY   = 3'd2;
  localparam logic [2:0]  OPO_RREPLY  = 3'd4;

  localparam logic [15:0] HW_ETHER  = 16'h0001;
  localparam logic [15:0] PROTO_IP4 = 16'h0800;
  localparam logic [7:0]  HW_LEN    = 8'd6;
  localparam logic [7:0]  PROTO_LEN = 8'd4;
  localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] REG_MY_IP   = 2'd0;
  localparam logic [1:0] REG_MY_MAC  = 2'd1;
  localparam logic [1:0] REG_PEND_TK = 2'd2;
  localparam logic [1:0] REG_VALID_TK = 2'd3;

  typedef struct packed {
    logic capture;
    logic scan;
    logic finish;
  } arc_cmd_t;

  typedef struct packed {
    logic scan_last;
  } arc_sts_t;

endpackage

// ===== rtl/arc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_ctrl
// Request sequencer: capture, slot scan, finish, hold result.
// ----------------------------------------------------------------------------
module arc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output arc_pkg::arc_cmd_t cmd_o,
  input  arc_pkg::arc_sts_t sts_i
);
  import arc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_WAIT = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_SCAN;
      S_SCAN: if (sts_i.scan_last) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_WAIT;
      S_WAIT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready     = (state_r == S_IDLE);
  assign out_tvalid    = (state_r == S_WAIT);
  assign cmd_o.capture = in_tready && in_tvalid;
  assign cmd_o.scan    = (state_r == S_SCAN);
  assign cmd_o.finish  = (state_r == S_FIN);

`ifndef ASSERT_OFF
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_SCAN) else $error("accept not followed by scan");
  a_fin_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |=> out_tvalid) else $error("finish not followed by result");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> in_tready) else $error("result taken but not idle");
`endif

endmodule

// ===== rtl/arc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_dp
// Datapath: config registers, slot table, scan accumulators, result register.
// ----------------------------------------------------------------------------
module arc_dp #(
  parameter int CACHE_SLOTS = arc_pkg::CACHE_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [1:0]                      cfg_index,
  input  logic [47:0]                     cfg_data,
  input  logic [1:0]                      in_tuser,
  input  logic [arc_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic [2:0]                      out_tuser,
  output logic [arc_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  arc_pkg::arc_cmd_t               cmd_i,
  output arc_pkg::arc_sts_t               sts_o
);
  import arc_pkg::*;

  localparam int IW = $clog2(CACHE_SLOTS);
  localparam logic [IW-1:0] LAST = IW'(CACHE_SLOTS - 1);

  logic [31:0] my_ip_r;
  logic [47:0] my_mac_r;
  logic [15:0] pend_tk_r, valid_tk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_ip_r    <= '0;
      my_mac_r   <= '0;
      pend_tk_r  <= 16'd1;
      valid_tk_r <= 16'd900;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MY_IP:    my_ip_r    <= cfg_data[31:0];
        REG_MY_MAC:   my_mac_r   <= cfg_data;
        REG_PEND_TK:  pend_tk_r  <= cfg_data[15:0];
        REG_VALID_TK: valid_tk_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [1:0]  cmd_r;
  logic [15:0] hw_r, pt_r, op_r;
  logic [7:0]  hl_r, pl_r;
  logic [47:0] smac_r, tmac_r;
  logic [31:0] sip_r, tip_r;
  logic        pub_in_r;

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      cmd_r    <= in_tuser;
      hw_r     <= in_tdata[15:0];
      pt_r     <= in_tdata[31:16];
      hl_r     <= in_tdata[39:32];
      pl_r     <= in_tdata[47:40];
      op_r     <= in_tdata[63:48];
      smac_r   <= in_tdata[111:64];
      sip_r    <= in_tdata[143:112];
      tmac_r   <= in_tdata[191:144];
      tip_r    <= in_tdata[223:192];
      pub_in_r <= in_tdata[224];
    end
  end

  logic        used_r [CACHE_SLOTS];
  logic        pend_r [CACHE_SLOTS];
  logic        stat_r [CACHE_SLOTS];
  logic        pub_r  [CACHE_SLOTS];
  logic [31:0] ip_r   [CACHE_SLOTS];
  logic [47:0] mac_r  [CACHE_SLOTS];
  logic [15:0] tick_r [CACHE_SLOTS];

  logic [IW-1:0] idx_r;
  logic          wr_en, wr_used, wr_pend, wr_stat, wr_pub;
  logic [IW-1:0] wr_idx;
  logic [31:0]   wr_ip;
  logic [47:0]   wr_mac;
  logic [15:0]   wr_tick;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CACHE_SLOTS; i++) used_r[i] <= 1'b0;
    end else if (wr_en) begin
      used_r[wr_idx] <= wr_used;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pend_r[wr_idx] <= wr_pend;
      stat_r[wr_idx] <= wr_stat;
      pub_r[wr_idx]  <= wr_pub;
      ip_r[wr_idx]   <= wr_ip;
      mac_r[wr_idx]  <= wr_mac;
      tick_r[wr_idx] <= wr_tick;
    end
  end

  logic        rd_used, rd_pend, rd_stat, rd_pub;
  logic [31:0] rd_ip;
  logic [47:0] rd_mac;
  logic [15:0] rd_tick;

  assign rd_used = used_r[idx_r];
  assign rd_pend = pend_r[idx_r];
  assign rd_stat = stat_r[idx_r];
  assign rd_pub  = pub_r[idx_r];
  assign rd_ip   = ip_r[idx_r];
  assign rd_mac  = mac_r[idx_r];
  assign rd_tick = tick_r[idx_r];

  logic          a_hit_r, b_hit_r, f_hit_r, m_hit_r;
  logic [IW-1:0] a_idx_r, f_idx_r;
  logic          a_stat_r, a_pend_r, b_pub_r, b_pend_r, m_pub_r;
  logic [47:0]   a_mac_r, b_mac_r;
  logic [31:0]   b_ip_r, m_ip_r;

  logic [31:0] a_key;
  logic        a_m, b_m, f_m, m_m, dyn_a, eff_pend, eff_pub;
  logic [47:0] eff_mac;

  always_comb begin
    a_key    = (cmd_r == CMD_PACKET) ? sip_r : tip_r;
    a_m      = rd_used && (rd_ip == a_key);
    b_m      = rd_used && (rd_ip == tip_r);
    f_m      = !rd_used;
    dyn_a    = a_m && !a_hit_r && !rd_stat && (cmd_r == CMD_PACKET);
    eff_pend = dyn_a ? 1'b0 : rd_pend;
    eff_pub  = dyn_a ? 1'b0 : rd_pub;
    eff_mac  = dyn_a ? smac_r : rd_mac;
    m_m      = rd_used && !eff_pend && (eff_mac == tmac_r);
  end

  assign sts_o.scan_last = cmd_i.scan && (idx_r == LAST);

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      idx_r   <= '0;
      a_hit_r <= 1'b0;
      b_hit_r <= 1'b0;
      f_hit_r <= 1'b0;
      m_hit_r <= 1'b0;
    end else if (cmd_i.scan) begin
      idx_r <= (idx_r == LAST) ? '0 : idx_r + 1'b1;
      if (a_m && !a_hit_r) begin
        a_hit_r  <= 1'b1;
        a_idx_r  <= idx_r;
        a_stat_r <= rd_stat;
        a_pend_r <= rd_pend;
        a_mac_r  <= rd_mac;
      end
      if (b_m && !b_hit_r) begin
        b_hit_r  <= 1'b1;
        b_pub_r  <= rd_pub;
        b_pend_r <= rd_pend;
        b_mac_r  <= rd_mac;
        b_ip_r   <= rd_ip;
      end
      if (f_m && !f_hit_r) begin
        f_hit_r <= 1'b1;
        f_idx_r <= idx_r;
      end
      if (m_m && !m_hit_r) begin
        m_hit_r <= 1'b1;
        m_pub_r <= eff_pub;
        m_ip_r  <= rd_ip;
      end
    end
  end

  logic [2:0]  act, sts, opo;
  logic [47:0] dst, osmac, otmac;
  logic [31:0] osip, otip;
  logic        rel;

  always_comb begin
    act = ACT_NONE; sts = ST_OK; opo = '0; rel = 1'b0;
    dst = '0; osmac = '0; otmac = '0; osip = '0; otip = '0;
    wr_en = 1'b0; wr_idx = idx_r;
    wr_used = rd_used; wr_pend = rd_pend; wr_stat = rd_stat; wr_pub = rd_pub;
    wr_ip = rd_ip; wr_mac = rd_mac; wr_tick = rd_tick;

    if (cmd_i.scan && cmd_r == CMD_TICK && rd_used && !rd_stat) begin
      wr_en = 1'b1;
      if (rd_tick <= 16'd1) begin
        wr_used = 1'b0;
      end else begin
        wr_tick = rd_tick - 16'd1;
      end
    end

    if (cmd_i.finish) begin
      case (cmd_r)
        CMD_PACKET: begin
          if (hw_r != HW_ETHER) begin
            sts = ST_BAD_HW;
          end else if (pt_r != PROTO_IP4) begin
            sts = ST_BAD_PRO;
          end else if (hl_r != HW_LEN || pl_r != PROTO_LEN) begin
            sts = ST_BAD_LEN;
          end else if (smac_r == MAC_BCAST) begin
            sts = ST_BCAST;
          end else begin
            wr_used = 1'b1; wr_pend = 1'b0; wr_stat = 1'b0; wr_pub = 1'b0;
            wr_ip = sip_r; wr_mac = smac_r; wr_tick = valid_tk_r;
            if (a_hit_r && !a_stat_r) begin
              wr_en  = 1'b1;
              wr_idx = a_idx_r;
              rel    = a_pend_r;
            end
            if (tip_r == my_ip_r) begin
              if (!a_hit_r) begin
                if (f_hit_r) begin
                  wr_en  = 1'b1;
                  wr_idx = f_idx_r;
                end else begin
                  sts = ST_FULL;
                end
              end
              if (op_r == OP_REQUEST) begin
                act = ACT_REPLY; opo = OPO_REPLY; dst = smac_r;
                osmac = my_mac_r; osip = my_ip_r; otmac = smac_r; otip = sip_r;
              end
            end else if (op_r == OP_REQUEST && b_hit_r && b_pub_r && !b_pend_r) begin
              act = ACT_REPLY; opo = OPO_REPLY; dst = smac_r;
              osmac = b_mac_r; osip = b_ip_r; otmac = smac_r; otip = sip_r;
            end else if (op_r == OP_RREQUEST && m_hit_r && m_pub_r) begin
              act = ACT_RREPLY; opo = OPO_RREPLY; dst = tmac_r;
              osmac = my_mac_r; osip = my_ip_r; otmac = tmac_r; otip = m_ip_r;
            end else begin
              sts = ST_IGNORED;
            end
          end
        end
        CMD_RESOLVE: begin
          if (a_hit_r) begin
            if (a_pend_r) begin
              act = ACT_QUENCH;
            end else begin
              act = ACT_RESOLVE;
              dst = a_mac_r;
            end
          end else if (f_hit_r) begin
            wr_en = 1'b1; wr_idx = f_idx_r;
            wr_used = 1'b1; wr_pend = 1'b1; wr_stat = 1'b0; wr_pub = 1'b0;
            wr_ip = tip_r; wr_mac = '0; wr_tick = pend_tk_r;
            act = ACT_REQUEST; opo = OPO_REQUEST; dst = MAC_BCAST;
            osmac = my_mac_r; osip = my_ip_r; otip = tip_r;
          end else begin
            sts = ST_FULL;
          end
        end
        CMD_INSTALL: begin
          wr_used = 1'b1; wr_pend = 1'b0; wr_stat = 1'b1; wr_pub = pub_in_r;
          wr_ip = tip_r; wr_mac = tmac_r; wr_tick = valid_tk_r;
          if (a_hit_r) begin
            wr_en  = 1'b1;
            wr_idx = a_idx_r;
            rel    = a_pend_r;
          end else if (f_hit_r) begin
            wr_en  = 1'b1;
            wr_idx = f_idx_r;
          end else begin
            sts = ST_FULL;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.finish) begin
      out_tuser <= act;
      out_tdata <= {1'b0, rel, otip, otmac, osip, osmac, opo, dst, sts};
    end
  end

`ifndef ASSERT_OFF
  a_scan_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    sts_o.scan_last |=> idx_r == '0) else $error("scan index did not wrap");
  a_fin_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.finish && cmd_r == CMD_TICK |-> !wr_en) else $error("write on tick finish");
  a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.finish && sts == ST_FULL && cmd_r != CMD_PACKET |-> !wr_en)
    else $error("write with full table");
`endif

endmodule

// ===== rtl/arp_responder_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_responder_cache
// ARP/RARP responder with an associative cache of IPv4 to MAC entries.
// ----------------------------------------------------------------------------
// After a request is accepted, the table is scanned slot by slot through its
// single read port; the finish state then resolves, writes back and loads the
// output register. The result waits there until taken, and the next request
// is accepted in the cycle after that.
// A new request is not accepted while one is scanned or waits.
// Configuration writes are always ready and take effect on the next cycle.
module arp_responder_cache #(
  parameter int CACHE_SLOTS = arc_pkg::CACHE_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [47:0]                    cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // cmd
  input  logic [1:0]                     in_tuser,
  // hw_type, proto_type, hw_len, proto_len, opcode, sender_mac, sender_ip,
  // target_mac, target IP, publish, zero pad
  input  logic [arc_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // action
  output logic [2:0]                     out_tuser,
  // status, dest_mac, out_opcode, out_sender_mac, out_sender_ip,
  // out_target_mac, out target IP, release_pending, zero pad
  output logic [arc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import arc_pkg::*;

  arc_cmd_t cmd;
  arc_sts_t sts;

  assign cfg_ready = 1'b1;

  arc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  arc_dp #(.CACHE_SLOTS(CACHE_SLOTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .cmd_i     (cmd),
    .sts_o     (sts)
  );

endmodule

// ===== sim/arp_responder_cache_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_responder_cache_tb
// Self-checking bench for the ARP responder cache. A directed table covers
// the header checks, broadcast sender, merge, proxy and reverse replies,
// resolve, quench, ticks and static installs. A random mix of mostly
// well-formed traffic on a small address pool follows, so the cache fills,
// ages and overflows. The run covers four register settings and four idle
// mixes. Results are checked by field with the table or a cache predictor.
// ----------------------------------------------------------------------------
module arp_responder_cache_tb;
  import arc_pkg::*;

  localparam int SLOTS = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PER_PHASE = 285;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] opcode;
    logic [47:0] smac;
    logic [31:0] sip;
    logic [47:0] tmac;
    logic [31:0] tip;
    logic        publish;
  } arp_in_t;

  typedef struct {
    logic [2:0]  action;
    logic [2:0]  status;
    logic [47:0] dest;
    logic [2:0]  op;
    logic [47:0] smac;
    logic [31:0] sip;
    logic [47:0] tmac;
    logic [31:0] tip;
    logic        rel;
  } arp_out_t;

  typedef struct {
    arp_in_t  req;
    logic     typed;
    arp_out_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [1:0] in_tuser = '0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [2:0] out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;

  arp_responder_cache uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tuser(out_tuser), .out_tdata(out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // cache predictor state
  logic [31:0] my_ip_r;
  logic [47:0] my_mac_r;
  logic [15:0] pend_life_r;
  logic [15:0] valid_life_r;
  logic        cache_used [SLOTS];
  logic        cache_pend [SLOTS];
  logic        cache_static [SLOTS];
  logic        cache_pub [SLOTS];
  logic [31:0] cache_ip [SLOTS];
  logic [47:0] cache_mac [SLOTS];
  logic [15:0] cache_life [SLOTS];

  arp_out_t expected_results [$];
  int errors = 0;
  int checked = 0;
  int sent = 0;
  int cycles = 0;
  int idle_mode = 0;
  int hold_cycles = 0;

  function automatic int find_ip(logic [31:0] ip);
    for (int i = 0; i < SLOTS; i++)
      if (cache_used[i] && cache_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic int find_free();
    for (int i = 0; i < SLOTS; i++)
      if (!cache_used[i]) return i;
    return -1;
  endfunction

  function automatic void fill_slot(int s, logic [31:0] ip, logic [47:0] mac);
    cache_used[s] = 1'b1;
    cache_pend[s] = 1'b0;
    cache_static[s] = 1'b0;
    cache_pub[s] = 1'b0;
    cache_ip[s] = ip;
    cache_mac[s] = mac;
    cache_life[s] = valid_life_r;
  endfunction

  function automatic void set_frame(ref arp_out_t r, input logic [2:0] op,
                                    input logic [47:0] dst, smac,
                                    input logic [31:0] sip,
                                    input logic [47:0] tmac,
                                    input logic [31:0] tip);
    r.dest = dst;
    r.op = op;
    r.smac = smac;
    r.sip = sip;
    r.tmac = tmac;
    r.tip = tip;
  endfunction

  function automatic arp_out_t predict_arp(arp_in_t it);
    arp_out_t r;
    int s;
    int k;
    logic merged;
    r = '{default: '0};
    case (it.cmd)
      CMD_PACKET: begin
        if (it.hw_type != HW_ETHER) r.status = ST_BAD_HW;
        else if (it.proto_type != PROTO_IP4) r.status = ST_BAD_PRO;
        else if (it.hw_len != HW_LEN || it.proto_len != PROTO_LEN) r.status = ST_BAD_LEN;
        else if (it.smac == MAC_BCAST) r.status = ST_BCAST;
        else begin
          s = find_ip(it.sip);
          merged = (s >= 0);
          if (merged && !cache_static[s]) begin
            if (cache_pend[s]) r.rel = 1'b1;
            fill_slot(s, it.sip, it.smac);
          end
          if (it.tip == my_ip_r) begin
            if (!merged) begin
              s = find_free();
              if (s < 0) r.status = ST_FULL;
              else fill_slot(s, it.sip, it.smac);
            end
            if (it.opcode == OP_REQUEST) begin
              r.action = ACT_REPLY;
              set_frame(r, OPO_REPLY, it.smac, my_mac_r, my_ip_r, it.smac, it.sip);
            end
            return r;
          end
          if (it.opcode == OP_REQUEST) begin
            s = find_ip(it.tip);
            if (s >= 0 && cache_pub[s] && !cache_pend[s]) begin
              r.action = ACT_REPLY;
              set_frame(r, OPO_REPLY, it.smac, cache_mac[s], cache_ip[s], it.smac, it.sip);
              return r;
            end
          end else if (it.opcode == OP_RREQUEST) begin
            k = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
              if (cache_used[i] && !cache_pend[i] && cache_mac[i] == it.tmac) k = i;
            if (k >= 0 && cache_pub[k]) begin
              r.action = ACT_RREPLY;
              set_frame(r, OPO_RREPLY, it.tmac, my_mac_r, my_ip_r, it.tmac, cache_ip[k]);
              return r;
            end
          end
          r.status = ST_IGNORED;
        end
      end
      CMD_RESOLVE: begin
        s = find_ip(it.tip);
        if (s >= 0) begin
          if (cache_pend[s]) r.action = ACT_QUENCH;
          else begin
            r.action = ACT_RESOLVE;
            r.dest = cache_mac[s];
          end
        end else begin
          s = find_free();
          if (s < 0) r.status = ST_FULL;
          else begin
            fill_slot(s, it.tip, '0);
            cache_pend[s] = 1'b1;
            cache_life[s] = pend_life_r;
            r.action = ACT_REQUEST;
            set_frame(r, OPO_REQUEST, MAC_BCAST, my_mac_r, my_ip_r, '0, it.tip);
          end
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < SLOTS; i++)
          if (cache_used[i] && !cache_static[i]) begin
            if (cache_life[i] <= 16'd1) cache_used[i] = 1'b0;
            else cache_life[i] = cache_life[i] - 16'd1;
          end
      end
      default: begin
        s = find_ip(it.tip);
        if (s < 0) begin
          s = find_free();
          if (s < 0) begin
            r.status = ST_FULL;
            return r;
          end
        end else if (cache_pend[s]) r.rel = 1'b1;
        fill_slot(s, it.tip, it.tmac);
        cache_static[s] = 1'b1;
        cache_pub[s] = it.publish;
      end
    endcase
    return r;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
  endtask

  // check results
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      arp_out_t want;
      arp_out_t got;
      got.action = out_tuser;
      {got.rel, got.tip, got.tmac, got.sip, got.smac, got.op, got.dest, got.status} =
        out_tdata[214:0];
      checked++;
      if (expected_results.size() == 0) report("unexpected result", out_tuser, 0);
      else begin
        want = expected_results.pop_front();
        if (got.action !== want.action) report("action", got.action, want.action);
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.dest !== want.dest) report("dest_mac", got.dest, want.dest);
        if (got.op !== want.op) report("out_opcode", got.op, want.op);
        if (got.smac !== want.smac) report("out_sender_mac", got.smac, want.smac);
        if (got.sip !== want.sip) report("out_sender_ip", got.sip, want.sip);
        if (got.tmac !== want.tmac) report("out_target_mac", got.tmac, want.tmac);
        if (got.tip !== want.tip) report("out_tgt_ip", got.tip, want.tip);
        if (got.rel !== want.rel) report("release_pending", got.rel, want.rel);
        if (out_tdata[215] !== 1'b0) report("pad bit", out_tdata[215], 0);
      end
    end
  end

  // receiver: hold off on request, else stall by idle mix
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready = 1'b0;
      hold_cycles--;
    end else if (idle_mode == 2) out_tready = ($urandom_range(99) >= 62);
    else if (idle_mode == 3) out_tready = ($urandom_range(99) >= 34);
    else out_tready = 1'b1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic sender_idle();
    if (idle_mode == 1) return $urandom_range(99) < 62;
    if (idle_mode == 3) return $urandom_range(99) < 34;
    return 1'b0;
  endfunction

  task automatic send_request(arp_in_t it, logic typed, arp_out_t want);
    arp_out_t p;
    @(negedge clk);
    while (sender_idle()) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = it.cmd;
    in_tdata = {7'b0, it.publish, it.tip, it.tmac, it.sip, it.smac, it.opcode,
                it.proto_len, it.hw_len, it.proto_type, it.hw_type};
    do @(posedge clk); while (!in_tready);
    p = predict_arp(it);
    expected_results.push_back(typed ? want : p);
    sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MY_IP: my_ip_r = val[31:0];
      REG_MY_MAC: my_mac_r = val;
      REG_PEND_TK: pend_life_r = val[15:0];
      default: valid_life_r = val[15:0];
    endcase
  endtask

  task automatic configure(logic [31:0] ip, logic [47:0] mac, logic [15:0] pl, logic [15:0] vl);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    write_reg(REG_MY_IP, {16'b0, ip});
    write_reg(REG_MY_MAC, mac);
    write_reg(REG_PEND_TK, {32'b0, pl});
    write_reg(REG_VALID_TK, {32'b0, vl});
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic arp_in_t arp_pkt(logic [15:0] op, logic [47:0] smac, logic [31:0] sip,
                                      logic [47:0] tmac, logic [31:0] tip);
    arp_in_t it;
    it = '{cmd: CMD_PACKET, hw_type: HW_ETHER, proto_type: PROTO_IP4, hw_len: HW_LEN,
           proto_len: PROTO_LEN, opcode: op, smac: smac, sip: sip, tmac: tmac,
           tip: tip, publish: 1'b0};
    return it;
  endfunction

  function automatic arp_in_t ctl_req(logic [1:0] cmd, logic [31:0] tip, logic [47:0] tmac,
                                      logic pub);
    arp_in_t it;
    it = arp_pkt('0, '0, '0, tmac, tip);
    it.cmd = cmd;
    it.publish = pub;
    return it;
  endfunction

  function automatic logic [31:0] pool_ip();
    if ($urandom_range(99) < 15) return my_ip_r;
    return 32'h0A00_0000 + $urandom_range(23);
  endfunction

  function automatic logic [47:0] pool_mac();
    if ($urandom_range(99) < 3) return MAC_BCAST;
    return 48'h0200_0000_0000 + $urandom_range(7);
  endfunction

  function automatic arp_in_t random_request();
    arp_in_t it;
    int r;
    logic [15:0] ops [6] = '{16'd1, 16'd1, 16'd2, 16'd3, 16'd4, 16'd0};
    r = $urandom_range(99);
    if (r < 6) begin
      it.cmd = 2'($urandom_range(3));
      it.hw_type = 16'($urandom);
      it.proto_type = 16'($urandom);
      it.hw_len = 8'($urandom);
      it.proto_len = 8'($urandom);
      it.opcode = 16'($urandom);
      it.smac = 48'({$urandom, $urandom});
      it.sip = $urandom;
      it.tmac = 48'({$urandom, $urandom});
      it.tip = $urandom;
      it.publish = 1'($urandom);
    end else if (r < 52) begin
      it = arp_pkt(ops[$urandom_range(5)], pool_mac(), pool_ip(), pool_mac(), pool_ip());
      if ($urandom_range(99) < 35) it.tip = my_ip_r;
      if ($urandom_range(99) < 8) begin
        case ($urandom_range(3))
          0: it.hw_type = 16'($urandom);
          1: it.proto_type = 16'($urandom);
          2: it.hw_len = 8'($urandom);
          default: it.proto_len = 8'($urandom);
        endcase
      end
    end else if (r < 73) it = ctl_req(CMD_RESOLVE, pool_ip(), '0, 1'b0);
    else if (r < 87) it = ctl_req(CMD_TICK, '0, '0, 1'b0);
    else it = ctl_req(CMD_INSTALL, pool_ip(), pool_mac(), 1'($urandom));
    return it;
  endfunction

  initial begin
    dir_row_t rows [$];
    dir_row_t row;
    arp_out_t none;
    arp_in_t it;
    logic [31:0] ph_ip [4] = '{32'hC0A8_0001, 32'hFFFF_FFFF, 32'h0, $urandom};
    logic [47:0] ph_mac [4] = '{48'h0200_0000_00AA, MAC_BCAST, 48'h0,
                                48'({$urandom, $urandom})};
    logic [15:0] ph_pl [4] = '{16'd1, 16'd65535, 16'd3, 16'd2};
    logic [15:0] ph_vl [4] = '{16'd1, 16'd65535, 16'd5, 16'd40};

    my_ip_r = '0;
    my_mac_r = '0;
    pend_life_r = 16'd1;
    valid_life_r = 16'd900;
    foreach (cache_used[i]) cache_used[i] = 1'b0;
    none = '{default: '0};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    row.typed = 1'b1;
    row.res = none;
    row.req = arp_pkt(OP_REQUEST, 48'h1, 32'h1, '0, 32'h5);
    row.req.hw_type = '0;
    row.res.status = ST_BAD_HW;
    rows.push_back(row);
    row.req.hw_type = HW_ETHER;
    row.req.proto_type = 16'hFFFF;
    row.res.status = ST_BAD_PRO;
    rows.push_back(row);
    row.req.proto_type = PROTO_IP4;
    row.req.hw_len = 8'hFF;
    row.res.status = ST_BAD_LEN;
    rows.push_back(row);
    row.req.hw_len = HW_LEN;
    row.req.proto_len = '0;
    rows.push_back(row);
    row.req.proto_len = PROTO_LEN;
    row.req.smac = MAC_BCAST;
    row.res.status = ST_BCAST;
    rows.push_back(row);
    row.req = ctl_req(CMD_RESOLVE, 32'hFFFF_FFFF, '0, 1'b0);
    row.res = none;
    row.res.action = ACT_REQUEST;
    row.res.dest = MAC_BCAST;
    row.res.op = OPO_REQUEST;
    row.res.tip = 32'hFFFF_FFFF;
    rows.push_back(row);
    row.res = none;
    row.res.action = ACT_QUENCH;
    rows.push_back(row);
    row.typed = 1'b0;
    row.req = arp_pkt(16'd2, 48'h0000_0000_0123, 32'hFFFF_FFFF, '0, 32'h5);
    rows.push_back(row);
    row.req = ctl_req(CMD_RESOLVE, 32'hFFFF_FFFF, '0, 1'b0);
    rows.push_back(row);
    row.req = ctl_req(CMD_INSTALL, 32'd10, 48'hAAA, 1'b1);
    rows.push_back(row);
    row.req = arp_pkt(OP_REQUEST, 48'h777, 32'd20, '0, 32'd10);
    rows.push_back(row);
    row.req = arp_pkt(OP_RREQUEST, 48'h777, 32'd20, 48'hAAA, 32'd99);
    rows.push_back(row);
    row.req = arp_pkt(OP_REQUEST, 48'h888, 32'd21, '0, 32'd0);
    rows.push_back(row);
    row.req = arp_pkt(16'd2, 48'h889, 32'd22, '0, 32'd0);
    rows.push_back(row);
    row.req = arp_pkt(16'd4, 48'h889, 32'd22, '0, 32'd40);
    rows.push_back(row);
    row.req = ctl_req(CMD_RESOLVE, 32'd30, '0, 1'b0);
    rows.push_back(row);
    row.req = ctl_req(CMD_INSTALL, 32'd30, 48'hFFFF_FFFF_FFFE, 1'b0);
    rows.push_back(row);
    row.req = arp_pkt(OP_REQUEST, 48'h1, 32'd2, '0, 32'd30);
    rows.push_back(row);
    row.req = ctl_req(CMD_RESOLVE, 32'd31, '0, 1'b0);
    rows.push_back(row);
    row.req = ctl_req(CMD_TICK, '0, '0, 1'b0);
    rows.push_back(row);
    row.req = ctl_req(CMD_RESOLVE, 32'd31, '0, 1'b0);
    rows.push_back(row);
    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].res);

    // random traffic over four settings and idle mixes
    for (int p = 0; p < 4; p++) begin
      configure(ph_ip[p], ph_mac[p], ph_pl[p], ph_vl[p]);
      idle_mode = p;
      if (p == 0) hold_cycles = 300;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        it = random_request();
        send_request(it, 1'b0, none);
        if (n == RANDOM_PER_PHASE / 2) begin
          // burst without gaps
          idle_mode = 0;
        end
        if (n == RANDOM_PER_PHASE * 3 / 4) idle_mode = p;
      end
    end
    @(negedge clk);
    in_tvalid = 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Run covered %0d requests and %0d checked results", sent, checked);
    $display("over four register settings, idle mixes and a long output hold-off.");
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/arc_pkg.sv
rtl/arc_ctrl.sv
rtl/arc_dp.sv
rtl/arp_responder_cache.sv
sim/arp_responder_cache_tb.sv
